/* rtl/k_smallest_sum_multiset_macros.svh */
// Assertion macros used by the k-smallest-sum multiset controller.
`ifndef K_SMALLEST_SUM_MULTISET_MACROS_SVH
`define K_SMALLEST_SUM_MULTISET_MACROS_SVH

// Same-cycle implication, disabled during reset
`define KSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define KSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/kss_pkg.sv */
// Package: word types, opcodes and controller/datapath interface structs.
`default_nettype none

package kss_pkg;

    localparam int OP_W  = 2;
    localparam int IV_W  = 10;
    localparam int QC_W  = 13;
    localparam int SUM_W = 22;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Command word
    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [IV_W-1:0]  item_value;
        logic [QC_W-1:0]  query_count;
    } kss_in_t;

    // Result word
    typedef struct packed {
        logic [SUM_W-1:0] smallest_sum;
        logic             too_few;
    } kss_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the command word
        logic clr;       // clear one tree node
        logic rd_check;  // read root, or leaf for a remove
        logic chk_pass;  // start an update walk at the root
        logic upd;       // one read-modify-write level
        logic qstart;    // start a query walk
        logic qstep;     // one query level
        logic mul;       // k times leaf value
        logic out_zero;  // emit a zero result
        logic out_sum;   // emit the collected sum
    } kss_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic op_ins;
        logic op_rem;
        logic op_qry;
        logic check_ok;
        logic q_short;
        logic q_zero;
        logic clr_last;
    } kss_stat_t;

endpackage

`default_nettype wire

/* rtl/kss_dp.sv */
// Datapath: count/sum tree memories, walk registers and result register.
`default_nettype none

module kss_dp
    import kss_pkg::*;
#(
    parameter int VALUE_BITS = 10,
    parameter int CAPACITY   = 4096
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire kss_in_t   cmd,
    input  wire kss_ctl_t  ctl,
    output kss_stat_t      stat,
    output logic           done,
    output kss_out_t       result
);

    localparam int VB    = VALUE_BITS;
    localparam int AW    = VALUE_BITS + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > QC_W) ? CNT_W : QC_W;
    localparam int PW    = (QC_W + VB > SUM_W) ? (QC_W + VB) : SUM_W;

    // Tree storage, node 0 unused
    logic [CNT_W-1:0] cnt_mem [0:DEPTH-1];
    logic [SUM_W-1:0] sum_mem [0:DEPTH-1];

    logic [CNT_W-1:0] rcnt_reg;
    logic [SUM_W-1:0] rsum_reg;

    kss_in_t          word_reg;
    logic [VB-1:0]    value_reg;
    logic [VB-1:0]    shift_reg;
    logic [AW-1:0]    node_reg;
    logic [QC_W-1:0]  k_reg;
    logic [SUM_W-1:0] total_reg;
    logic [SUM_W-1:0] prod_reg;
    logic [AW-1:0]    clr_addr_reg;
    logic             done_reg;
    kss_out_t         result_reg;

    logic             we;
    logic [AW-1:0]    wa;
    logic [CNT_W-1:0] wcnt;
    logic [SUM_W-1:0] wsum;
    logic             re;
    logic [AW-1:0]    ra;

    logic             in_range;
    logic             go_left;
    logic [AW-1:0]    next_q;
    logic [CMP_W-1:0] k_sub;
    logic [PW-1:0]    prod_full;

    // Decode of the latched word
    assign in_range = (word_reg.item_value >> VALUE_BITS) == '0;
    assign stat.op_ins  = (word_reg.opcode == OP_INSERT) && in_range;
    assign stat.op_rem  = (word_reg.opcode == OP_REMOVE) && in_range;
    assign stat.op_qry  = (word_reg.opcode == OP_QUERY);
    assign stat.check_ok = (word_reg.opcode == OP_REMOVE) ? (rcnt_reg != '0)
                         : (CMP_W'(rcnt_reg) < CMP_W'(CAPACITY));
    assign stat.q_short  = CMP_W'(word_reg.query_count) > CMP_W'(rcnt_reg);
    assign stat.q_zero   = word_reg.query_count == '0;
    assign stat.clr_last = clr_addr_reg == '1;

    // Query step decision
    assign go_left = CMP_W'(k_reg) <= CMP_W'(rcnt_reg);
    assign next_q  = {node_reg[AW-2:0], ~go_left};
    assign k_sub   = CMP_W'(k_reg) - CMP_W'(rcnt_reg);
    assign prod_full = PW'(k_reg) * PW'(node_reg[VB-1:0]);

    // Memory port control
    always_comb
    begin
        we   = 1'b0;
        wa   = node_reg;
        wcnt = rcnt_reg + CNT_W'(1);
        wsum = rsum_reg + SUM_W'(value_reg);
        re   = 1'b0;
        ra   = AW'(1);
        if (ctl.clr)
        begin
            we   = 1'b1;
            wa   = clr_addr_reg;
            wcnt = '0;
            wsum = '0;
        end
        if (ctl.rd_check)
        begin
            re = 1'b1;
            ra = stat.op_rem ? {1'b1, value_reg} : AW'(1);
        end
        if (ctl.chk_pass)
        begin
            re = 1'b1;
            ra = AW'(1);
        end
        if (ctl.upd)
        begin
            we = 1'b1;
            if (word_reg.opcode == OP_REMOVE)
            begin
                wcnt = rcnt_reg - CNT_W'(1);
                wsum = rsum_reg - SUM_W'(value_reg);
            end
            re = 1'b1;
            ra = {node_reg[AW-2:0], shift_reg[VB-1]};
        end
        if (ctl.qstart)
        begin
            re = 1'b1;
            ra = AW'(2);
        end
        if (ctl.qstep)
        begin
            re = 1'b1;
            ra = {next_q[AW-2:0], 1'b0};
        end
    end

    // Tree memories, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cnt_mem[wa] <= wcnt;
            sum_mem[wa] <= wsum;
        end
        if (re)
        begin
            rcnt_reg <= cnt_mem[ra];
            rsum_reg <= sum_mem[ra];
        end
    end

    // Walk and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            word_reg  <= cmd;
            value_reg <= VB'(cmd.item_value);
        end
        if (ctl.chk_pass)
        begin
            node_reg  <= AW'(1);
            shift_reg <= value_reg;
        end
        if (ctl.upd)
        begin
            node_reg  <= {node_reg[AW-2:0], shift_reg[VB-1]};
            shift_reg <= shift_reg << 1;
        end
        if (ctl.qstart)
        begin
            node_reg  <= AW'(1);
            total_reg <= '0;
            k_reg     <= word_reg.query_count;
        end
        if (ctl.qstep)
        begin
            node_reg <= next_q;
            if (!go_left)
            begin
                total_reg <= total_reg + rsum_reg;
                k_reg     <= k_sub[QC_W-1:0];
            end
        end
        if (ctl.mul)
            prod_reg <= prod_full[SUM_W-1:0];
        if (ctl.out_zero)
        begin
            result_reg.smallest_sum <= '0;
            result_reg.too_few      <= stat.q_short;
        end
        if (ctl.out_sum)
        begin
            result_reg.smallest_sum <= total_reg + prod_reg;
            result_reg.too_few      <= 1'b0;
        end
    end

    // Clear sweep address and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            done_reg <= ctl.out_zero | ctl.out_sum;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/kss_ctrl.sv */
// Controller: state machine sequencing clear sweep, updates and queries.
`default_nettype none
`include "k_smallest_sum_multiset_macros.svh"

module kss_ctrl
    import kss_pkg::*;
#(
    parameter int VALUE_BITS = 10
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire kss_stat_t stat,
    output logic           busy,
    output kss_ctl_t       ctl
);

    localparam int LVL_W = $clog2(VALUE_BITS + 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_UPD   = 4'd4;
    localparam logic [3:0] S_QCHK  = 4'd5;
    localparam logic [3:0] S_QWALK = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        ctl        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clr = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.op_ins || stat.op_rem)
                begin
                    ctl.rd_check = 1'b1;
                    state_next   = S_CHECK;
                end
                else if (stat.op_qry)
                begin
                    ctl.rd_check = 1'b1;
                    state_next   = S_QCHK;
                end
                else
                    state_next = S_IDLE;
            end
            S_CHECK:
            begin
                if (stat.check_ok)
                begin
                    ctl.chk_pass = 1'b1;
                    lvl_next     = '0;
                    state_next   = S_UPD;
                end
                else
                    state_next = S_IDLE;
            end
            S_UPD:
            begin
                ctl.upd = 1'b1;
                if (lvl_reg == LVL_W'(VALUE_BITS))
                    state_next = S_IDLE;
                else
                    lvl_next = lvl_reg + LVL_W'(1);
            end
            S_QCHK:
            begin
                if (stat.q_short || stat.q_zero)
                begin
                    ctl.out_zero = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    ctl.qstart = 1'b1;
                    lvl_next   = '0;
                    state_next = S_QWALK;
                end
            end
            S_QWALK:
            begin
                ctl.qstep = 1'b1;
                if (lvl_reg == LVL_W'(VALUE_BITS - 1))
                    state_next = S_MUL;
                else
                    lvl_next = lvl_reg + LVL_W'(1);
            end
            S_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                ctl.out_sum = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            lvl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
        end
    end

    assign busy = state_reg != S_IDLE;

    // Checks
    `KSS_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, start && !busy, state_reg == S_DISP, "accepted word not dispatched")
    `KSS_ASSERT_IMPL(a_upd_level, clk, rst_n, state_reg == S_UPD, lvl_reg <= LVL_W'(VALUE_BITS), "update walk past leaf")
    `KSS_ASSERT_IMPL(a_qwalk_level, clk, rst_n, state_reg == S_QWALK, lvl_reg < LVL_W'(VALUE_BITS), "query walk past leaf")
    `KSS_ASSERT_IMPL(a_cmd_excl, clk, rst_n, 1'b1, $onehot0({ctl.clr, ctl.upd, ctl.qstep, ctl.out_zero, ctl.out_sum}), "conflicting datapath commands")

endmodule

`default_nettype wire

/* rtl/k_smallest_sum_multiset.sv */
// Top level: multiset with count/sum tree answering k-smallest-sum queries.
//
//  channel  | ports                  | handshake
//  ---------+------------------------+-------------------------------------
//  command  | start, busy, cmd       | taken at clk edge with start && !busy
//  result   | done, result           | one-cycle strobe, cannot be held off
//
// After reset the tree is swept clear, one node a cycle, over all
// 2^(VALUE_BITS+1) nodes (2048 by default), with busy high.
// Insert/remove: one tree level a cycle, reading the child node while the
// current node is written; a rejected insert/remove ends without update.
// Query: tree walk, then k times leaf value; short/zero-k give a zero sum.
// The result strobe comes in the first cycle with busy low; it never stalls.
`default_nettype none

module k_smallest_sum_multiset
    import kss_pkg::*;
#(
    parameter int VALUE_BITS = 10,
    parameter int CAPACITY   = 4096
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire kss_in_t cmd,
    output logic         busy,
    output logic         done,
    output kss_out_t     result
);

    kss_ctl_t  ctl;
    kss_stat_t stat;

    kss_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .ctl   (ctl)
    );

    kss_dp #(
        .VALUE_BITS (VALUE_BITS),
        .CAPACITY   (CAPACITY)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctl    (ctl),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire
